### design/chained_multimap_store_core_macros.svh
// Assertion macros for the chained multimap store core.
// Depends on signals named clk and rst_n in the module that includes this file.
`ifndef CHAINED_MULTIMAP_STORE_CORE_MACROS_SVH
`define CHAINED_MULTIMAP_STORE_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define CMS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CMS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cms_pkg.sv
// Package for the chained multimap store: sizes, codes and payload types.
// No dependencies; imported by chained_multimap_store_core.
package cms_pkg;

    localparam int RECORDS   = 1024;
    localparam int POSTINGS  = 4096;
    localparam int NODE_BITS = 32;

    localparam int REC_W    = 10;
    localparam int HIDX_W   = $clog2(RECORDS);
    localparam int PIDX_W   = $clog2(POSTINGS);
    localparam int LINK_W   = $clog2(POSTINGS + 1);
    localparam int RLIM_W   = 11;
    localparam int NLIM_W   = 33;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = NLIM_W;

    localparam logic [RLIM_W-1:0] RECORD_LIMIT_RESET = RLIM_W'(1024);
    localparam logic [NLIM_W-1:0] NODE_LIMIT_RESET   = NLIM_W'(64'h1_0000_0000);

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT   = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FIRST  = 2'd2,
        ACT_NEXT   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOCUR   = 3'd3,
        ST_CYCLE   = 3'd4,
        ST_CORRUPT = 3'd5
    } status_t;

    typedef struct packed {
        action_t               action;
        logic [REC_W-1:0]      record_index;
        logic [NODE_BITS-1:0]  node_in;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [NODE_BITS-1:0]  node_out;
        logic [LINK_W-1:0]     postings_used;
    } result_t;

    // One posting: its record, its node and the link (number plus one) to
    // the previous posting of the same record, zero at the chain end.
    typedef struct packed {
        logic [REC_W-1:0]      record;
        logic [NODE_BITS-1:0]  node;
        logic [LINK_W-1:0]     link;
    } posting_t;

endpackage

### design/chained_multimap_store_core.sv
// Chained multimap store: head table and posting store in synchronous RAMs.
// Depends on cms_pkg and chained_multimap_store_core_macros.svh.
//
// Usage. Items arrive on the item channel (item_valid, item_stall, item) and
// each produces exactly one transaction on the result channel (result_valid,
// result_stall, result). A transaction moves at a clock edge where valid is
// high and stall is low. Limits are written through cfg_wr_en, cfg_index and
// cfg_data while the block is idle; they take effect on the next item.
// The block works on one item at a time. For append and first, the accepting
// cycle issues the head table read, state S_HEAD issues the posting read that
// its link selects, and state S_POST evaluates, writes back and loads the
// result into the output register. Next and clear skip the head read and go
// from acceptance straight to S_POST; next issues its posting read from the
// cursor link in the accepting cycle. The dependent chain of head RAM read
// and posting RAM read sets this order of steps.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits; if the receiver stalls, the following item
// waits in its final cycle until the output register is free.
// Reset empties the store with no clearing pass: a head entry counts as live
// only when its link lies within the posting count and the posting it names
// belongs to that record, so resetting the count is enough. The cursor is
// dropped and the limits return to 1024 records and 2^32 nodes.
`include "chained_multimap_store_core_macros.svh"

module chained_multimap_store_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  cms_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output cms_pkg::result_t               result,
    input  logic                           cfg_wr_en,
    input  logic [cms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cms_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_POST
    } state_t;

    // Control state.
    state_t               state_reg, state_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;
    logic [LINK_W-1:0]    posting_total_reg, posting_total_next;
    logic [REC_W-1:0]     cursor_record_reg, cursor_record_next;
    logic [LINK_W-1:0]    cursor_link_reg, cursor_link_next;
    logic [LINK_W-1:0]    cursor_visited_reg, cursor_visited_next;
    logic                 cursor_live_reg, cursor_live_next;
    logic [RLIM_W-1:0]    record_limit_reg;
    logic [NLIM_W-1:0]    node_limit_reg;

    // The item under work.
    action_t              act_reg;
    logic [REC_W-1:0]     rec_reg;
    logic [NODE_BITS-1:0] node_reg;

    // Memories and their ports.
    logic [LINK_W-1:0]    head_mem [RECORDS];
    posting_t             post_mem [POSTINGS];
    logic [LINK_W-1:0]    head_rdata_reg;
    posting_t             post_rdata_reg;
    logic                 head_re, head_we, post_re, post_we;
    logic [HIDX_W-1:0]    head_raddr, head_waddr;
    logic [PIDX_W-1:0]    post_raddr, post_waddr;
    logic [LINK_W-1:0]    head_wdata;
    posting_t             post_wdata;

    logic                 fire;
    logic                 head_hit;
    logic                 rec_ok, cur_rec_ok, node_in_ok, post_node_ok, post_link_ok;
    status_t              status;
    logic                 found;
    logic [NODE_BITS-1:0] found_node;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The final cycle may complete only when the output register is free.
    assign fire = (state_reg == S_POST) && (!result_valid_reg || !result_stall);

    assign rec_ok       = ({1'b0, rec_reg} < record_limit_reg) &&
                          ({1'b0, rec_reg} < RLIM_W'(RECORDS));
    assign cur_rec_ok   = ({1'b0, cursor_record_reg} < record_limit_reg) &&
                          ({1'b0, cursor_record_reg} < RLIM_W'(RECORDS));
    assign node_in_ok   = ({1'b0, node_reg} < node_limit_reg);
    assign post_node_ok = ({1'b0, post_rdata_reg.node} < node_limit_reg);
    assign post_link_ok = (post_rdata_reg.link <= posting_total_reg);

    // A head entry is live when its link points inside the posting count at
    // a posting of the same record. Such a posting was written after the
    // last clear, and writing it also wrote this head entry.
    always_comb
    begin
        head_hit = 1'b0;
        if ((head_rdata_reg != '0) && (head_rdata_reg <= posting_total_reg) &&
            (post_rdata_reg.record == rec_reg))
        begin
            head_hit = 1'b1;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        result_valid_next   = result_valid_reg && result_stall;
        result_next         = result_reg;
        posting_total_next  = posting_total_reg;
        cursor_record_next  = cursor_record_reg;
        cursor_link_next    = cursor_link_reg;
        cursor_visited_next = cursor_visited_reg;
        cursor_live_next    = cursor_live_reg;
        head_re    = 1'b0;
        head_raddr = item.record_index[HIDX_W-1:0];
        post_re    = 1'b0;
        post_raddr = PIDX_W'(cursor_link_reg - LINK_W'(1));
        head_we    = 1'b0;
        head_waddr = rec_reg[HIDX_W-1:0];
        head_wdata = posting_total_reg + LINK_W'(1);
        post_we    = 1'b0;
        post_waddr = posting_total_reg[PIDX_W-1:0];
        post_wdata = '{record: rec_reg, node: node_reg,
                       link: head_hit ? head_rdata_reg : '0};
        status     = ST_OK;
        found      = 1'b0;
        found_node = post_rdata_reg.node;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.action) inside
                        ACT_APPEND, ACT_FIRST:
                        begin
                            head_re    = 1'b1;
                            state_next = S_HEAD;
                        end
                        ACT_NEXT:
                        begin
                            // The cursor already holds the link to follow.
                            post_re    = 1'b1;
                            state_next = S_POST;
                        end
                        default:
                        begin
                            state_next = S_POST;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                post_re    = 1'b1;
                post_raddr = PIDX_W'(head_rdata_reg - LINK_W'(1));
                state_next = S_POST;
            end
            S_POST:
            begin
                if (fire)
                begin
                    unique case (act_reg)
                        ACT_CLEAR:
                        begin
                            posting_total_next = '0;
                            cursor_live_next   = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            if (!rec_ok || !node_in_ok)
                            begin
                                status = ST_RANGE;
                            end
                            else if (posting_total_reg >= LINK_W'(POSTINGS))
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                post_we            = 1'b1;
                                head_we            = 1'b1;
                                posting_total_next = posting_total_reg + LINK_W'(1);
                            end
                        end
                        ACT_FIRST:
                        begin
                            if (!rec_ok)
                            begin
                                status = ST_RANGE;
                            end
                            else
                            begin
                                cursor_record_next  = rec_reg;
                                cursor_link_next    = '0;
                                cursor_visited_next = '0;
                                cursor_live_next    = 1'b1;
                                if (head_hit)
                                begin
                                    if (post_node_ok && post_link_ok)
                                    begin
                                        found               = 1'b1;
                                        cursor_link_next    = post_rdata_reg.link;
                                        cursor_visited_next = LINK_W'(1);
                                    end
                                    else
                                    begin
                                        status = ST_CORRUPT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (!cursor_live_reg || !cur_rec_ok)
                            begin
                                status = ST_NOCUR;
                            end
                            else if (cursor_link_reg != '0)
                            begin
                                if (cursor_visited_reg >= posting_total_reg)
                                begin
                                    status = ST_CYCLE;
                                end
                                else if ((cursor_link_reg > posting_total_reg) ||
                                         (post_rdata_reg.record != cursor_record_reg) ||
                                         !post_node_ok || !post_link_ok)
                                begin
                                    status = ST_CORRUPT;
                                end
                                else
                                begin
                                    found               = 1'b1;
                                    cursor_link_next    = post_rdata_reg.link;
                                    cursor_visited_next = cursor_visited_reg + LINK_W'(1);
                                end
                            end
                        end
                    endcase

                    result_valid_next = 1'b1;
                    result_next = '{status: status, found: found,
                                    node_out: found ? found_node : '0,
                                    postings_used: posting_total_next};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            result_valid_reg   <= 1'b0;
            result_reg         <= '0;
            posting_total_reg  <= '0;
            cursor_record_reg  <= '0;
            cursor_link_reg    <= '0;
            cursor_visited_reg <= '0;
            cursor_live_reg    <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            result_valid_reg   <= result_valid_next;
            result_reg         <= result_next;
            posting_total_reg  <= posting_total_next;
            cursor_record_reg  <= cursor_record_next;
            cursor_link_reg    <= cursor_link_next;
            cursor_visited_reg <= cursor_visited_next;
            cursor_live_reg    <= cursor_live_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_limit_reg <= RECORD_LIMIT_RESET;
            node_limit_reg   <= NODE_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RECORD_LIMIT: record_limit_reg <= cfg_data[RLIM_W-1:0];
                CFG_NODE_LIMIT:   node_limit_reg   <= cfg_data[NLIM_W-1:0];
                default:          record_limit_reg <= record_limit_reg;
            endcase
        end
    end

    // Item capture; payload only.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            act_reg  <= item.action;
            rec_reg  <= item.record_index;
            node_reg <= item.node_in;
        end
    end

    // Head table RAM. Reads and writes never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re)
        begin
            head_rdata_reg <= head_mem[head_raddr];
        end
    end

    // Posting store RAM.
    always_ff @(posedge clk)
    begin
        if (post_we)
        begin
            post_mem[post_waddr] <= post_wdata;
        end
        if (post_re)
        begin
            post_rdata_reg <= post_mem[post_raddr];
        end
    end

    // Checks on the internal bookkeeping.
    `CMS_ASSERT_ALWAYS(a_total_bound, posting_total_reg <= LINK_W'(POSTINGS),
        "posting count exceeds store depth")
    `CMS_ASSERT_IMPLIES(a_visited_bound, cursor_live_reg,
        cursor_visited_reg <= posting_total_reg, "cursor visit count beyond posting count")
    `CMS_ASSERT_IMPLIES(a_found_ok, result_valid_reg && result_reg.found,
        result_reg.status == ST_OK, "node returned with an error status")
    `CMS_ASSERT_NEXT(a_accept_busy, item_valid && !item_stall,
        state_reg == S_HEAD || state_reg == S_POST, "accepted item did not start work")

endmodule
